>>> hdl/tbb_pkg.sv
package tbb_pkg;

   // register indexes on the csr write channel
   localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_INK_THRESHOLD = 2'd2;

   localparam int DIM_BITS    = 13;
   localparam int PIXEL_BITS  = 8;
   localparam int COORD_BITS  = 12;

   localparam logic [DIM_BITS-1:0]   FRAME_WIDTH_RESET   = 13'd4096;
   localparam logic [DIM_BITS-1:0]   FRAME_HEIGHT_RESET  = 13'd4096;
   localparam logic [PIXEL_BITS-1:0] INK_THRESHOLD_RESET = 8'd128;
   localparam logic [PIXEL_BITS-1:0] PAPER_PIXEL         = 8'd255;

endpackage

>>> hdl/threshold_bounding_box.sv
// Threshold bounding box: thresholds a raster-order grayscale stream and reports
// the bounding box of all ink pixels (value at or below the threshold).
// Input channel req_: one 8-bit pixel per transfer, row by row; the block
// counts column and row itself from the frame_width / frame_height registers.
// Result channel rsp_: one result per pixel, the thresholded pixel and, on the
// last pixel of a frame (rsp_frame_end), the box of that frame or all zeros
// when no ink was seen.
// Configuration channel csr_: index 0 frame width, 1 frame height, 2 ink
// threshold; csr_ready is always high. Write only while the stream is idle.
// An input transfer's result is in the output register in the next cycle;
// one pixel is taken every cycle when not stalled (single register stage).
// When rsp_stall is high while a result waits, req_stall rises and the result
// holds; both sides resume in the cycle the stall drops.
// Reset restores the register defaults (4096 x 4096, threshold 128), starts a
// new frame and empties the output register.
module threshold_bounding_box
   import tbb_pkg::*;
#(
   parameter int MAX_DIM = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PIXEL_BITS-1:0] req_pixel_in,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                  rsp_frame_end,
   output logic                  rsp_box_found,
   output logic [COORD_BITS-1:0] rsp_box_left,
   output logic [COORD_BITS-1:0] rsp_box_top,
   output logic [DIM_BITS-1:0]   rsp_box_width,
   output logic [DIM_BITS-1:0]   rsp_box_height,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [DIM_BITS-1:0]   csr_data
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int EW = (CW + 2 > DIM_BITS + 1) ? CW + 2 : DIM_BITS + 1;
   localparam logic [EW-1:0] MAX_DIM_EXT = EW'(MAX_DIM);

   logic [DIM_BITS-1:0]   frame_width_ff, frame_height_ff;
   logic [PIXEL_BITS-1:0] ink_threshold_ff;

   logic [CW-1:0] column_count_ff, column_count_in;
   logic [CW-1:0] row_count_ff, row_count_in;
   logic [CW-1:0] min_column_ff, min_column_in, max_column_ff, max_column_in;
   logic [CW-1:0] min_row_ff, min_row_in, max_row_ff, max_row_in;
   logic          ink_seen_ff, ink_seen_in;

   logic                  rsp_valid_ff;
   logic [PIXEL_BITS-1:0] pixel_out_ff, pixel_out_in;
   logic                  frame_end_ff, frame_end_in;
   logic                  box_found_ff, box_found_in;
   logic [COORD_BITS-1:0] box_left_ff, box_left_in, box_top_ff, box_top_in;
   logic [DIM_BITS-1:0]   box_width_ff, box_width_in, box_height_ff, box_height_in;

   logic [EW-1:0] width_eff, height_eff;
   logic          last_col, last_row, is_ink, req_accept;

   assign csr_ready  = 1'b1;
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // zero acts as one, anything above the maximum acts as the maximum
   always_comb begin
      width_eff  = EW'(frame_width_ff);
      height_eff = EW'(frame_height_ff);
      if (frame_width_ff == '0) width_eff = EW'(1);
      else if (width_eff > MAX_DIM_EXT) width_eff = MAX_DIM_EXT;
      if (frame_height_ff == '0) height_eff = EW'(1);
      else if (height_eff > MAX_DIM_EXT) height_eff = MAX_DIM_EXT;
   end

   assign last_col = EW'(column_count_ff) >= width_eff - EW'(1);
   assign last_row = EW'(row_count_ff) >= height_eff - EW'(1);
   assign is_ink   = req_pixel_in <= ink_threshold_ff;

   always_comb begin
      min_column_in = min_column_ff;
      max_column_in = max_column_ff;
      min_row_in    = min_row_ff;
      max_row_in    = max_row_ff;
      ink_seen_in   = ink_seen_ff;
      pixel_out_in  = PAPER_PIXEL;
      if (is_ink) begin
         if (!ink_seen_ff || column_count_ff < min_column_ff) min_column_in = column_count_ff;
         if (!ink_seen_ff || column_count_ff > max_column_ff) max_column_in = column_count_ff;
         if (!ink_seen_ff || row_count_ff < min_row_ff) min_row_in = row_count_ff;
         if (!ink_seen_ff || row_count_ff > max_row_ff) max_row_in = row_count_ff;
         ink_seen_in  = 1'b1;
         pixel_out_in = req_pixel_in;
      end

      frame_end_in  = last_col && last_row;
      box_found_in  = 1'b0;
      box_left_in   = '0;
      box_top_in    = '0;
      box_width_in  = '0;
      box_height_in = '0;
      if (frame_end_in && ink_seen_in) begin
         box_found_in  = 1'b1;
         box_left_in   = COORD_BITS'(min_column_in);
         box_top_in    = COORD_BITS'(min_row_in);
         box_width_in  = DIM_BITS'(max_column_in) - DIM_BITS'(min_column_in) + DIM_BITS'(1);
         box_height_in = DIM_BITS'(max_row_in) - DIM_BITS'(min_row_in) + DIM_BITS'(1);
      end

      column_count_in = column_count_ff + CW'(1);
      row_count_in    = row_count_ff;
      if (frame_end_in) begin
         column_count_in = '0;
         row_count_in    = '0;
         ink_seen_in     = 1'b0;
         min_column_in   = '1;
         max_column_in   = '0;
         min_row_in      = '1;
         max_row_in      = '0;
      end else if (last_col) begin
         column_count_in = '0;
         row_count_in    = row_count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff   <= FRAME_WIDTH_RESET;
         frame_height_ff  <= FRAME_HEIGHT_RESET;
         ink_threshold_ff <= INK_THRESHOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_FRAME_WIDTH:   frame_width_ff   <= csr_data;
            REG_FRAME_HEIGHT:  frame_height_ff  <= csr_data;
            REG_INK_THRESHOLD: ink_threshold_ff <= csr_data[PIXEL_BITS-1:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         min_column_ff   <= '1;
         max_column_ff   <= '0;
         min_row_ff      <= '1;
         max_row_ff      <= '0;
         ink_seen_ff     <= 1'b0;
      end else if (req_accept) begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         min_column_ff   <= min_column_in;
         max_column_ff   <= max_column_in;
         min_row_ff      <= min_row_in;
         max_row_ff      <= max_row_in;
         ink_seen_ff     <= ink_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pixel_out_ff  <= pixel_out_in;
         frame_end_ff  <= frame_end_in;
         box_found_ff  <= box_found_in;
         box_left_ff   <= box_left_in;
         box_top_ff    <= box_top_in;
         box_width_ff  <= box_width_in;
         box_height_ff <= box_height_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = pixel_out_ff;
   assign rsp_frame_end  = frame_end_ff;
   assign rsp_box_found  = box_found_ff;
   assign rsp_box_left   = box_left_ff;
   assign rsp_box_top    = box_top_ff;
   assign rsp_box_width  = box_width_ff;
   assign rsp_box_height = box_height_ff;

   // last pixel of a frame leaves the tracking state cleared
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      req_accept && last_col && last_row |=>
         column_count_ff == '0 && row_count_ff == '0 && !ink_seen_ff)
      else $error("tracking state not restarted after frame end");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      ink_seen_ff |-> min_column_ff <= max_column_ff && min_row_ff <= max_row_ff)
      else $error("bounding box minimum above maximum");

   a_box_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_box_found |->
         rsp_box_left == '0 && rsp_box_top == '0 &&
         rsp_box_width == '0 && rsp_box_height == '0)
      else $error("box fields set without a box");

   a_found_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_box_found |-> rsp_frame_end && rsp_box_width != '0)
      else $error("box reported away from frame end");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted pixel produced no result");

endmodule

>>> tb/threshold_bounding_box_test.sv
module threshold_bounding_box_test import tbb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM  = 4096;
   localparam int IDLE_PCT = 28;
   // index 3 addresses no register and must be ignored
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_out;
      logic                  frame_end;
      logic                  box_found;
      logic [COORD_BITS-1:0] box_left;
      logic [COORD_BITS-1:0] box_top;
      logic [DIM_BITS-1:0]   box_width;
      logic [DIM_BITS-1:0]   box_height;
   } box_result_type;

   typedef enum {ROW_PIXEL, ROW_WIDTH, ROW_HEIGHT, ROW_THRESHOLD} row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [DIM_BITS-1:0] value;
      bit                  typed;
      box_result_type      want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [PIXEL_BITS-1:0] req_pixel_in = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [PIXEL_BITS-1:0] rsp_pixel_out;
   logic                  rsp_frame_end;
   logic                  rsp_box_found;
   logic [COORD_BITS-1:0] rsp_box_left;
   logic [COORD_BITS-1:0] rsp_box_top;
   logic [DIM_BITS-1:0]   rsp_box_width;
   logic [DIM_BITS-1:0]   rsp_box_height;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index = REG_FRAME_WIDTH;
   logic [DIM_BITS-1:0]   csr_data = '0;

   // register copies and frame tracking of the predictor
   logic [DIM_BITS-1:0]   width_reg  = FRAME_WIDTH_RESET;
   logic [DIM_BITS-1:0]   height_reg = FRAME_HEIGHT_RESET;
   logic [PIXEL_BITS-1:0] ink_level  = INK_THRESHOLD_RESET;
   logic [COORD_BITS-1:0] col_cnt = '0;
   logic [COORD_BITS-1:0] row_cnt = '0;
   logic [COORD_BITS-1:0] min_col = '1;
   logic [COORD_BITS-1:0] max_col = '0;
   logic [COORD_BITS-1:0] min_row = '1;
   logic [COORD_BITS-1:0] max_row = '0;
   bit                    ink_seen = 1'b0;

   box_result_type awaited_results [$];
   int             mismatches = 0;
   int             idle_pct = IDLE_PCT;

   stim_row_type directed_rows [23] = '{
      '{ROW_PIXEL, 13'd0, 1'b1, '{8'd0, 1'b0, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      '{ROW_PIXEL, 13'd128, 1'b1, '{8'd128, 1'b0, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      '{ROW_PIXEL, 13'd129, 1'b1, '{8'd255, 1'b0, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      '{ROW_PIXEL, 13'd255, 1'b1, '{8'd255, 1'b0, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      // zero dimensions act as one: the open frame ends on the next pixel
      '{ROW_WIDTH, 13'd0, 1'b0, '0},
      '{ROW_HEIGHT, 13'd0, 1'b0, '0},
      '{ROW_PIXEL, 13'd200, 1'b1, '{8'd255, 1'b1, 1'b1, 12'd0, 12'd0, 13'd2, 13'd1}},
      '{ROW_PIXEL, 13'd255, 1'b1, '{8'd255, 1'b1, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      '{ROW_PIXEL, 13'd5, 1'b1, '{8'd5, 1'b1, 1'b1, 12'd0, 12'd0, 13'd1, 13'd1}},
      '{ROW_THRESHOLD, 13'd0, 1'b0, '0},
      '{ROW_PIXEL, 13'd0, 1'b1, '{8'd0, 1'b1, 1'b1, 12'd0, 12'd0, 13'd1, 13'd1}},
      '{ROW_PIXEL, 13'd1, 1'b1, '{8'd255, 1'b1, 1'b0, 12'd0, 12'd0, 13'd0, 13'd0}},
      '{ROW_THRESHOLD, 13'h1FFF, 1'b0, '0},
      '{ROW_PIXEL, 13'd255, 1'b1, '{8'd255, 1'b1, 1'b1, 12'd0, 12'd0, 13'd1, 13'd1}},
      '{ROW_WIDTH, 13'd3, 1'b0, '0},
      '{ROW_HEIGHT, 13'd2, 1'b0, '0},
      '{ROW_THRESHOLD, 13'd100, 1'b0, '0},
      '{ROW_PIXEL, 13'd150, 1'b0, '0},
      '{ROW_PIXEL, 13'd100, 1'b0, '0},
      '{ROW_PIXEL, 13'd101, 1'b0, '0},
      '{ROW_PIXEL, 13'd7, 1'b0, '0},
      '{ROW_PIXEL, 13'd255, 1'b0, '0},
      '{ROW_PIXEL, 13'd60, 1'b0, '0}
   };

   threshold_bounding_box u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_box_found  (rsp_box_found),
      .rsp_box_left   (rsp_box_left),
      .rsp_box_top    (rsp_box_top),
      .rsp_box_width  (rsp_box_width),
      .rsp_box_height (rsp_box_height),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int dim_in_force(input logic [DIM_BITS-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_DIM) return MAX_DIM;
      return int'(value);
   endfunction

   function automatic box_result_type threshold_pixel(input logic [PIXEL_BITS-1:0] pix);
      box_result_type res;
      int             w;
      int             h;
      bit             last_col;
      bit             last_row;
      w        = dim_in_force(width_reg);
      h        = dim_in_force(height_reg);
      last_col = int'(col_cnt) >= w - 1;
      last_row = int'(row_cnt) >= h - 1;
      res      = '0;
      if (pix <= ink_level) begin
         if (!ink_seen || col_cnt < min_col) min_col = col_cnt;
         if (!ink_seen || col_cnt > max_col) max_col = col_cnt;
         if (!ink_seen || row_cnt < min_row) min_row = row_cnt;
         if (!ink_seen || row_cnt > max_row) max_row = row_cnt;
         ink_seen      = 1'b1;
         res.pixel_out = pix;
      end else begin
         res.pixel_out = PAPER_PIXEL;
      end
      if (last_col && last_row) begin
         res.frame_end = 1'b1;
         if (ink_seen) begin
            res.box_found  = 1'b1;
            res.box_left   = min_col;
            res.box_top    = min_row;
            res.box_width  = DIM_BITS'(max_col) - DIM_BITS'(min_col) + DIM_BITS'(1);
            res.box_height = DIM_BITS'(max_row) - DIM_BITS'(min_row) + DIM_BITS'(1);
         end
         col_cnt  = '0;
         row_cnt  = '0;
         min_col  = '1;
         max_col  = '0;
         min_row  = '1;
         max_row  = '0;
         ink_seen = 1'b0;
      end else if (last_col) begin
         col_cnt = '0;
         row_cnt = row_cnt + COORD_BITS'(1);
      end else begin
         col_cnt = col_cnt + COORD_BITS'(1);
      end
      return res;
   endfunction

   task automatic send_pixel(input logic [PIXEL_BITS-1:0] pix, input bit typed = 1'b0,
                             input box_result_type want = '0);
      box_result_type predicted;
      csr_valid <= 1'b0;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= pix;
      do @(posedge clock); while (req_stall);
      predicted = threshold_pixel(pix);
      awaited_results.push_back(typed ? want : predicted);
   endtask

   // registers only change once the stream has drained
   task automatic write_reg(input logic [1:0] index, input logic [DIM_BITS-1:0] data);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         REG_FRAME_WIDTH:   width_reg  = data;
         REG_FRAME_HEIGHT:  height_reg = data;
         REG_INK_THRESHOLD: ink_level  = data[PIXEL_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= idle_pct != 0 && $urandom_range(99) < idle_pct;
   end

   always @(posedge clock) begin
      box_result_type got;
      box_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_pixel_out, rsp_frame_end, rsp_box_found, rsp_box_left, rsp_box_top,
                rsp_box_width, rsp_box_height};
         if (awaited_results.size() == 0) begin
            $error("result transfer with no pixel awaiting it");
            mismatches++;
         end else begin
            want = awaited_results.pop_front();
            compare_field("pixel_out", 16'(want.pixel_out), 16'(got.pixel_out));
            compare_field("frame_end", 16'(want.frame_end), 16'(got.frame_end));
            compare_field("box_found", 16'(want.box_found), 16'(got.box_found));
            compare_field("box_left", 16'(want.box_left), 16'(got.box_left));
            compare_field("box_top", 16'(want.box_top), 16'(got.box_top));
            compare_field("box_width", 16'(want.box_width), 16'(got.box_width));
            compare_field("box_height", 16'(want.box_height), 16'(got.box_height));
         end
      end
   end

   initial begin
      int pixels_sent;
      int phase;
      int burst;
      pixels_sent = 0;
      phase       = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_PIXEL: send_pixel(directed_rows[i].value[PIXEL_BITS-1:0],
                                  directed_rows[i].typed, directed_rows[i].want);
            ROW_WIDTH:  write_reg(REG_FRAME_WIDTH, directed_rows[i].value);
            ROW_HEIGHT: write_reg(REG_FRAME_HEIGHT, directed_rows[i].value);
            default:    write_reg(REG_INK_THRESHOLD, directed_rows[i].value);
         endcase
      end

      // small frames, registers rewritten between bursts, often mid-frame
      // oversized dimensions act as the maximum until a smaller one cuts the row short
      while (pixels_sent < 430) begin
         phase++;
         idle_pct = (phase >= 12 && phase < 20) ? 0 : IDLE_PCT;
         repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(0, 3))
               0: case ($urandom_range(7))
                     0: write_reg(REG_FRAME_WIDTH, '0);
                     1: write_reg(REG_FRAME_WIDTH, DIM_BITS'($urandom_range(4096, 8191)));
                     default: write_reg(REG_FRAME_WIDTH, DIM_BITS'($urandom_range(1, 6)));
                  endcase
               1: case ($urandom_range(7))
                     0: write_reg(REG_FRAME_HEIGHT, '0);
                     1: write_reg(REG_FRAME_HEIGHT, DIM_BITS'($urandom_range(4096, 8191)));
                     default: write_reg(REG_FRAME_HEIGHT, DIM_BITS'($urandom_range(1, 5)));
                  endcase
               2: case ($urandom_range(3))
                     0: write_reg(REG_INK_THRESHOLD, {5'($urandom), 8'd0});
                     1: write_reg(REG_INK_THRESHOLD, {5'($urandom), 8'd255});
                     default: write_reg(REG_INK_THRESHOLD, DIM_BITS'($urandom));
                  endcase
               default: write_reg(REG_UNUSED, DIM_BITS'($urandom));
            endcase
         end
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            case ($urandom_range(7))
               0: send_pixel(8'd0);
               1: send_pixel(8'd255);
               2: send_pixel(ink_level);
               3: send_pixel(ink_level + 1'b1);
               default: send_pixel(PIXEL_BITS'($urandom_range(255)));
            endcase
         end
         pixels_sent += burst;
      end

      // close the open frame
      idle_pct = IDLE_PCT;
      write_reg(REG_FRAME_WIDTH, 13'd1);
      write_reg(REG_FRAME_HEIGHT, 13'd1);
      write_reg(REG_INK_THRESHOLD, 13'd50);
      send_pixel(8'd0);

      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule
